>>> sv/adi_pkg.sv
// shared widths, register indexes and reset values of the detrend integrator
package adi_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 16;
  localparam int STEP_W     = 16;
  localparam int DET_W      = 21;
  localparam int VEL_W      = 32;
  localparam int DIST_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP = 2'd1;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd40182;
  localparam logic [STEP_W-1:0] STEP_RESET = 16'd2621;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [DET_W-1:0]    det_t;
  typedef logic signed [VEL_W-1:0]    vel_t;
  typedef logic        [DIST_W-1:0]   dist_t;

  // handshake between a producer and a queue
  typedef struct packed {
    logic push;
    logic full;
  } q_wr_t;

endpackage

>>> sv/accel_detrend_integrator.sv
// top level of the accelerometer detrend and double integrator
//
// One signed sample (g/4096) goes in per word; once WINDOW samples have filled
// the ring, every further sample yields one word of detrended acceleration,
// velocity and distance (all scaled by 4096, SI units). The front blocks a
// new sample while the ring, a single-port memory, refreshes its registered
// read of the next slot after each write. Samples that give a result pass
// through a two-word queue to the back sequencer, which spends a pop plus
// nine steps on each sample (the divide by WINDOW done as two reciprocal
// multiplies on a shared product register) and holds its last step while
// the output register is full; it takes no new sample before it is through
// with the last one. The queue and the output register absorb short bursts
// and stalls on either side. Config words are accepted every cycle
// (cfg_ready is always high) and must only be written while no sample is
// in flight.
module accel_detrend_integrator #(
  parameter int WINDOW = 25
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // sample input
  input  logic                               in_push,
  input  logic signed [15:0]                 in_accel_sample,
  output logic                               in_full,
  // result output
  input  logic                               out_pop,
  output logic                               out_empty,
  output logic signed [20:0]                 out_detrended_accel,
  output logic signed [31:0]                 out_velocity,
  output logic        [31:0]                 out_distance,
  // config write
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [adi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [adi_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // window sum of raw samples needs ceil(log2(WINDOW)) guard bits
  localparam int SUM_W  = adi_pkg::SAMPLE_W + $clog2(WINDOW);
  localparam int ITEM_W = adi_pkg::SAMPLE_W + SUM_W;

  logic [adi_pkg::GAIN_W-1:0] gain_r;
  logic [adi_pkg::STEP_W-1:0] step_r;

  adi_pkg::q_wr_t             q_wr;
  logic                       q_full;
  logic                       q_empty;
  logic                       q_pop;
  adi_pkg::sample_t           f_sample;
  logic signed [SUM_W-1:0]    f_sum;
  logic [ITEM_W-1:0]          q_rd_data;
  adi_pkg::sample_t           b_sample;
  logic signed [SUM_W-1:0]    b_sum;

  // config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= adi_pkg::GAIN_RESET;
      step_r <= adi_pkg::STEP_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        adi_pkg::REG_GAIN: gain_r <= cfg_data;
        adi_pkg::REG_STEP: step_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: ring, running sum, fill phase
  adi_front #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_accel_sample (in_accel_sample),
    .in_full         (in_full),
    .q_wr            (q_wr),
    .q_full          (q_full),
    .q_sample        (f_sample),
    .q_sum           (f_sum)
  );

  // sample plus window sum before it
  adi_queue #(
    .ITEM_W (ITEM_W)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_wr.push),
    .wr_data ({f_sample, f_sum}),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_data (q_rd_data)
  );

  assign b_sample = q_rd_data[ITEM_W-1 -: adi_pkg::SAMPLE_W];
  assign b_sum    = q_rd_data[SUM_W-1:0];

  // back: detrend and double integration
  adi_back #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_empty             (q_empty),
    .q_pop               (q_pop),
    .q_sample            (b_sample),
    .q_sum               (b_sum),
    .gain                (gain_r),
    .step                (step_r),
    .out_pop             (out_pop),
    .out_empty           (out_empty),
    .out_detrended_accel (out_detrended_accel),
    .out_velocity        (out_velocity),
    .out_distance        (out_distance)
  );

endmodule

>>> sv/adi_queue.sv
// two-entry word queue between the front and the back
module adi_queue #(
  parameter int ITEM_W = 37
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [ITEM_W-1:0] wr_data,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output logic [ITEM_W-1:0] rd_data
);

  logic [ITEM_W-1:0] slot_r [2];
  logic              wr_ptr_r;
  logic              rd_ptr_r;
  logic [1:0]        count_r;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign rd_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("word pushed into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("word popped from empty queue");

endmodule

>>> sv/adi_front.sv
// sample ring, running window sum and fill tracking
module adi_front #(
  parameter int WINDOW = 25,
  parameter int SUM_W  = 21
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  input  adi_pkg::sample_t           in_accel_sample,
  output logic                       in_full,
  output adi_pkg::q_wr_t             q_wr,
  input  logic                       q_full,
  output adi_pkg::sample_t           q_sample,
  output logic signed [SUM_W-1:0]    q_sum
);

  localparam int PTR_W = $clog2(WINDOW);
  localparam int FC_W  = $clog2(WINDOW + 1);

  adi_pkg::sample_t          ring_mem [WINDOW];
  adi_pkg::sample_t          old_r;
  logic [PTR_W-1:0]          ptr_r;
  logic [FC_W-1:0]           fill_r;
  logic signed [SUM_W-1:0]   sum_r;
  logic signed [SUM_W-1:0]   sum_nxt;
  logic                      busy_r;
  logic                      filled;
  logic                      accept;

  assign filled  = (fill_r == FC_W'(WINDOW));
  assign in_full = busy_r || (filled && q_full);
  assign accept  = in_push && !in_full;

  assign q_wr.push = accept && filled;
  assign q_wr.full = q_full;
  assign q_sample  = in_accel_sample;
  assign q_sum     = sum_r;

  // the oldest slot only counts once the ring holds a whole window
  always_comb begin
    sum_nxt = sum_r + SUM_W'(in_accel_sample);
    if (filled) begin
      sum_nxt = sum_nxt - SUM_W'(old_r);
    end
  end

  // ring read runs every cycle at the write slot; the front stays busy after each sample while it refreshes
  always_ff @(posedge clk) begin
    old_r <= ring_mem[ptr_r];
    if (accept) begin
      ring_mem[ptr_r] <= in_accel_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r  <= '0;
      fill_r <= '0;
      sum_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      busy_r <= accept;
      if (accept) begin
        sum_r <= sum_nxt;
        ptr_r <= (ptr_r == PTR_W'(WINDOW - 1)) ? '0 : ptr_r + PTR_W'(1);
        if (!filled) begin
          fill_r <= fill_r + FC_W'(1);
        end
      end
    end
  end

  a_refresh_gap: assert property (@(posedge clk) disable iff (!rst_n) accept |=> in_full)
    else $error("sample taken before ring read refreshed");

endmodule

>>> sv/adi_back.sv
// detrend, velocity and distance sequencer with output register
module adi_back #(
  parameter int WINDOW = 25,
  parameter int SUM_W  = 21
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  output logic                          q_pop,
  input  adi_pkg::sample_t              q_sample,
  input  logic signed [SUM_W-1:0]       q_sum,
  input  logic [adi_pkg::GAIN_W-1:0]    gain,
  input  logic [adi_pkg::STEP_W-1:0]    step,
  input  logic                          out_pop,
  output logic                          out_empty,
  output adi_pkg::det_t                 out_detrended_accel,
  output adi_pkg::vel_t                 out_velocity,
  output adi_pkg::dist_t                out_distance
);

  // divide by WINDOW as multiply by ceil(2^K / WINDOW), exact for dividends below 2^N
  localparam int N   = SUM_W;
  localparam int L   = $clog2(WINDOW);
  localparam int K   = N + L;
  localparam int R_W = N + 2;
  localparam int PW  = N + R_W;
  localparam int QW  = N - L + 1;
  localparam longint unsigned RECIP = ((64'd1 << K) + longint'(WINDOW) - 64'd1) /
                                      longint'(WINDOW);
  localparam logic [R_W-1:0] RECIP_V = R_W'(RECIP);
  localparam logic [N-1:0]   WIN_N   = N'(WINDOW);

  localparam int P_W  = adi_pkg::SAMPLE_W + adi_pkg::GAIN_W + 1;
  localparam int D_W  = P_W + 1;
  localparam int DV_W = adi_pkg::STEP_W + 1 + adi_pkg::DET_W;
  localparam int VP_W = adi_pkg::STEP_W + 1 + adi_pkg::VEL_W;
  localparam int VS_W = adi_pkg::VEL_W + 7;
  localparam int DS_W = adi_pkg::DIST_W + 2;

  localparam logic signed [D_W-1:0]  DET_HI = (D_W'(1) <<< (adi_pkg::DET_W - 1)) - D_W'(1);
  localparam logic signed [D_W-1:0]  DET_LO = -(D_W'(1) <<< (adi_pkg::DET_W - 1));
  localparam logic signed [VS_W-1:0] VEL_HI = (VS_W'(1) <<< (adi_pkg::VEL_W - 1)) - VS_W'(1);
  localparam logic signed [VS_W-1:0] VEL_LO = -(VS_W'(1) <<< (adi_pkg::VEL_W - 1));
  localparam logic [DS_W-1:0]        DIST_HI = (DS_W'(1) << adi_pkg::DIST_W) - DS_W'(1);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MUL  = 4'd1;
  localparam logic [3:0] ST_QUO  = 4'd2;
  localparam logic [3:0] ST_REM  = 4'd3;
  localparam logic [3:0] ST_RMUL = 4'd4;
  localparam logic [3:0] ST_DET  = 4'd5;
  localparam logic [3:0] ST_VMUL = 4'd6;
  localparam logic [3:0] ST_VACC = 4'd7;
  localparam logic [3:0] ST_DMUL = 4'd8;
  localparam logic [3:0] ST_DACC = 4'd9;

  logic [3:0]                st_r, st_nxt;
  adi_pkg::sample_t          s_r;
  logic [N-1:0]              xm_r;
  logic                      neg_r;
  logic signed [P_W-1:0]     p_r;
  logic [PW-1:0]             qprod_r;
  logic [QW-1:0]             q_r;
  logic [N-1:0]              y_r;
  logic [31:0]               qg_r;
  adi_pkg::det_t             det_r, det_nxt;
  logic signed [DV_W-1:0]    dvprod_r;
  adi_pkg::vel_t             vel_acc_r, vel_nxt;
  logic signed [VP_W-1:0]    vprod_r;
  adi_pkg::dist_t            dist_acc_r, dist_nxt;
  logic                      out_valid_r;
  adi_pkg::det_t             out_det_r;
  adi_pkg::vel_t             out_vel_r;
  adi_pkg::dist_t            out_dist_r;

  logic [QW-1:0]             quo;
  logic [N-1:0]              rem;
  logic [32:0]               m_mag;
  logic signed [D_W-1:0]     m_s, diff, det_full;
  logic signed [VS_W-1:0]    dv, vsum;
  logic [VP_W-1:0]           vmag;
  logic [DS_W-1:0]           dsum;
  logic                      out_load;

  assign q_pop     = (st_r == ST_IDLE) && !q_empty;
  assign out_load  = (st_r == ST_DACC) && (!out_valid_r || out_pop);
  assign out_empty = !out_valid_r;
  assign out_detrended_accel = out_det_r;
  assign out_velocity        = out_vel_r;
  assign out_distance        = out_dist_r;

  assign quo = qprod_r[K +: QW];
  assign rem = xm_r - N'(q_r) * WIN_N;

  always_comb begin
    m_mag    = 33'(qg_r) + 33'(quo);
    m_s      = neg_r ? -$signed({1'b0, m_mag}) : $signed({1'b0, m_mag});
    diff     = p_r - m_s;
    det_full = diff >>> 12;
    if (det_full > DET_HI) begin
      det_nxt = DET_HI[adi_pkg::DET_W-1:0];
    end else if (det_full < DET_LO) begin
      det_nxt = DET_LO[adi_pkg::DET_W-1:0];
    end else begin
      det_nxt = det_full[adi_pkg::DET_W-1:0];
    end
  end

  always_comb begin
    dv   = VS_W'(dvprod_r >>> 16);
    vsum = VS_W'(vel_acc_r) + dv;
    if (vsum > VEL_HI) begin
      vel_nxt = VEL_HI[adi_pkg::VEL_W-1:0];
    end else if (vsum < VEL_LO) begin
      vel_nxt = VEL_LO[adi_pkg::VEL_W-1:0];
    end else begin
      vel_nxt = vsum[adi_pkg::VEL_W-1:0];
    end
  end

  always_comb begin
    vmag = vprod_r[VP_W-1] ? VP_W'(-vprod_r) : VP_W'(vprod_r);
    dsum = DS_W'(dist_acc_r) + DS_W'(vmag[VP_W-1:16]);
    dist_nxt = (dsum > DIST_HI) ? DIST_HI[adi_pkg::DIST_W-1:0] : dsum[adi_pkg::DIST_W-1:0];
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (!q_empty) st_nxt = ST_MUL;
      ST_MUL:  st_nxt = ST_QUO;
      ST_QUO:  st_nxt = ST_REM;
      ST_REM:  st_nxt = ST_RMUL;
      ST_RMUL: st_nxt = ST_DET;
      ST_DET:  st_nxt = ST_VMUL;
      ST_VMUL: st_nxt = ST_VACC;
      ST_VACC: st_nxt = ST_DMUL;
      ST_DMUL: st_nxt = ST_DACC;
      ST_DACC: if (out_load) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // datapath registers, updated per sequencer step
  always_ff @(posedge clk) begin
    case (st_r)
      ST_IDLE: begin
        s_r   <= q_sample;
        neg_r <= q_sum[SUM_W-1];
        xm_r  <= q_sum[SUM_W-1] ? N'(~q_sum + SUM_W'(1)) : N'(q_sum);
      end
      ST_MUL: begin
        p_r     <= s_r * $signed({1'b0, gain});
        qprod_r <= PW'(xm_r) * PW'(RECIP_V);
      end
      ST_QUO: q_r <= quo;
      ST_REM: begin
        y_r  <= N'(rem[L-1:0]) * N'(gain);
        qg_r <= 32'(q_r) * 32'(gain);
      end
      ST_RMUL: qprod_r <= PW'(y_r) * PW'(RECIP_V);
      ST_DET:  det_r <= det_nxt;
      ST_VMUL: dvprod_r <= $signed({1'b0, step}) * det_r;
      ST_DMUL: vprod_r <= $signed({1'b0, step}) * vel_acc_r;
      default: ;
    endcase
    if (out_load) begin
      out_det_r  <= det_r;
      out_vel_r  <= vel_acc_r;
      out_dist_r <= dist_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      vel_acc_r   <= '0;
      dist_acc_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_VACC) begin
        vel_acc_r <= vel_nxt;
      end
      if (out_load) begin
        dist_acc_r  <= dist_nxt;
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_vel_one_step: assert property (@(posedge clk) disable iff (!rst_n)
      (st_r != ST_VACC) |=> $stable(vel_acc_r))
    else $error("velocity changed outside its update step");
  a_dist_monotone: assert property (@(posedge clk) disable iff (!rst_n)
      out_load |=> (dist_acc_r >= $past(dist_acc_r)))
    else $error("distance decreased");

endmodule
